// ----- hdl/cdeq_pkg.sv -----
// Shared types, codes and widths for the circular double-ended queue.
`default_nettype none

package cdeq_pkg;

   localparam int DEPTH_DEF  = 128;
   localparam int DATA_W     = 32;
   localparam int REQ_TYPE_W = 2;
   localparam int STATUS_W   = 2;
   localparam int REQ_TDATA_W = 32;
   localparam int RSP_TDATA_W = 40;

   // request kinds
   localparam logic [REQ_TYPE_W-1:0] OP_INS_FRONT = 2'd0;
   localparam logic [REQ_TYPE_W-1:0] OP_INS_REAR  = 2'd1;
   localparam logic [REQ_TYPE_W-1:0] OP_REM_FRONT = 2'd2;
   localparam logic [REQ_TYPE_W-1:0] OP_REM_REAR  = 2'd3;

   // result status codes
   localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
   localparam logic [STATUS_W-1:0] ST_OVERFLOW  = 2'd1;
   localparam logic [STATUS_W-1:0] ST_UNDERFLOW = 2'd2;

   // outcome of one request, from the index logic to the result stage
   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic                is_empty;
      logic                is_full;
      logic                rd_pending;
   } ctrl_result_type;

endpackage

`default_nettype wire

// ----- hdl/circular_double_ended_queue_top.sv -----
// Top level of the circular double-ended queue: handshake, result register, checks.
//
//  channel | dir | ports                          | contents
//  --------+-----+--------------------------------+--------------------------------------
//  req     | in  | req_tvalid/tready/tdata/tuser  | tuser: req_type; tdata: data_in
//  rsp     | out | rsp_tvalid/tready/tdata/tuser  | tuser: status; tdata: data_out, flags
//
// Inserts and refused requests: result registered in the cycle after the transfer, so
// one request per cycle while results are taken. Successful removes: the word passes the
// registered ring read port, then the result register; req_tready is low during the read.
// Reset clears indices, occupancy and the result valid; ring contents are not cleared.
// A stalled result (rsp_tready low) holds and blocks new requests.
`default_nettype none

module circular_double_ended_queue_top #(
   parameter int DEPTH = cdeq_pkg::DEPTH_DEF
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_tvalid,
   output logic                                   req_tready,
   input  wire logic [cdeq_pkg::REQ_TDATA_W-1:0]  req_tdata,  // [31:0] data_in
   input  wire logic [cdeq_pkg::REQ_TYPE_W-1:0]   req_tuser,  // [1:0] req_type
   output logic                                   rsp_tvalid,
   input  wire logic                              rsp_tready,
   output logic      [cdeq_pkg::RSP_TDATA_W-1:0]  rsp_tdata,  // [31:0] data_out,
                                                              // [32] is_empty,
                                                              // [33] is_full, rest zero
   output logic      [cdeq_pkg::STATUS_W-1:0]     rsp_tuser   // [1:0] status
);
   import cdeq_pkg::*;

   localparam int IDX_W = $clog2(DEPTH);

   logic               req_fire;
   logic               wr_en, rd_en;
   logic [IDX_W-1:0]   wr_addr, rd_addr;
   logic [DATA_W-1:0]  rd_data;
   ctrl_result_type    res;

   logic               pend_ff, pend_in;
   ctrl_result_type    pend_info_ff;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0] rsp_status_ff, rsp_status_in;
   logic [DATA_W-1:0]  rsp_data_ff, rsp_data_in;
   logic               rsp_empty_ff, rsp_empty_in;
   logic               rsp_full_ff, rsp_full_in;
   logic               rsp_load;

   assign req_tready = !pend_ff && (!rsp_valid_ff || rsp_tready);
   assign req_fire   = req_tvalid && req_tready;

   cdeq_ctrl #(.DEPTH(DEPTH)) u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .req_fire (req_fire),
      .req_type (req_tuser),
      .wr_en    (wr_en),
      .wr_addr  (wr_addr),
      .rd_en    (rd_en),
      .rd_addr  (rd_addr),
      .res      (res)
   );

   cdeq_ring #(.DEPTH(DEPTH)) u_ring (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (req_tdata[DATA_W-1:0]),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign pend_in = req_fire && res.rd_pending;

   always_comb begin
      rsp_load      = 1'b0;
      rsp_valid_in  = rsp_valid_ff;
      rsp_status_in = rsp_status_ff;
      rsp_data_in   = rsp_data_ff;
      rsp_empty_in  = rsp_empty_ff;
      rsp_full_in   = rsp_full_ff;
      if (pend_ff) begin
         // read data lands: finish the remove
         rsp_load      = 1'b1;
         rsp_valid_in  = 1'b1;
         rsp_status_in = pend_info_ff.status;
         rsp_data_in   = rd_data;
         rsp_empty_in  = pend_info_ff.is_empty;
         rsp_full_in   = pend_info_ff.is_full;
      end else if (req_fire && !res.rd_pending) begin
         rsp_load      = 1'b1;
         rsp_valid_in  = 1'b1;
         rsp_status_in = res.status;
         rsp_data_in   = '0;
         rsp_empty_in  = res.is_empty;
         rsp_full_in   = res.is_full;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pend_in) begin
         pend_info_ff <= res;
      end
      if (rsp_load) begin
         rsp_status_ff <= rsp_status_in;
         rsp_data_ff   <= rsp_data_in;
         rsp_empty_ff  <= rsp_empty_in;
         rsp_full_ff   <= rsp_full_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_status_ff;
   assign rsp_tdata  = {{(RSP_TDATA_W - DATA_W - 2){1'b0}},
                        rsp_full_ff, rsp_empty_ff, rsp_data_ff};

   // a remove that read the ring shows its result in the very next cycle
   a_read_completes: assert property (@(posedge clock) disable iff (reset)
      pend_ff |=> rsp_tvalid)
      else $error("ring read did not produce a result");

   // no request is taken while a ring read is outstanding
   a_read_interlock: assert property (@(posedge clock) disable iff (reset)
      pend_ff |-> !req_fire)
      else $error("request accepted during outstanding read");

   // a refused remove means the deque is empty and carries no word
   a_underflow_empty: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser == ST_UNDERFLOW) |->
         (rsp_tdata[DATA_W] && rsp_tdata[DATA_W-1:0] == '0))
      else $error("underflow result with data or non-empty flag");

   // overflow only when full, and never empty and full together
   a_flags_consistent: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (!(rsp_tdata[DATA_W] && rsp_tdata[DATA_W+1]) &&
                      (rsp_tuser != ST_OVERFLOW || rsp_tdata[DATA_W+1])))
      else $error("inconsistent empty/full flags");

endmodule

`default_nettype wire

// ----- hdl/cdeq_ring.sv -----
// Ring storage: one write port, one registered read port.
`default_nettype none

module cdeq_ring #(
   parameter int DEPTH = cdeq_pkg::DEPTH_DEF
) (
   input  wire logic                         clock,
   input  wire logic                         wr_en,
   input  wire logic [$clog2(DEPTH)-1:0]     wr_addr,
   input  wire logic [cdeq_pkg::DATA_W-1:0]  wr_data,
   input  wire logic                         rd_en,
   input  wire logic [$clog2(DEPTH)-1:0]     rd_addr,
   output logic      [cdeq_pkg::DATA_W-1:0]  rd_data
);
   import cdeq_pkg::*;

   logic [DATA_W-1:0] ring_mem [DEPTH];
   logic [DATA_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         ring_mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= ring_mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ----- hdl/cdeq_ctrl.sv -----
// Front/rear indices, occupancy and the per-request ring access decision.
`default_nettype none

module cdeq_ctrl #(
   parameter int DEPTH = cdeq_pkg::DEPTH_DEF
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             req_fire,
   input  wire logic [cdeq_pkg::REQ_TYPE_W-1:0]  req_type,
   output logic                                  wr_en,
   output logic      [$clog2(DEPTH)-1:0]         wr_addr,
   output logic                                  rd_en,
   output logic      [$clog2(DEPTH)-1:0]         rd_addr,
   output cdeq_pkg::ctrl_result_type             res
);
   import cdeq_pkg::*;

   localparam int IDX_W = $clog2(DEPTH);
   localparam int OCC_W = $clog2(DEPTH + 1);
   localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(DEPTH - 1);
   localparam logic [OCC_W-1:0] OCC_FULL = OCC_W'(DEPTH);

   logic [IDX_W-1:0] front_ff, front_in;
   logic [IDX_W-1:0] rear_ff, rear_in;
   logic [OCC_W-1:0] occ_ff, occ_in;
   logic [IDX_W-1:0] front_prev, front_next, rear_prev, rear_next;
   logic             was_empty, was_full, do_wr, do_rd;

   assign was_empty  = (occ_ff == '0);
   assign was_full   = (occ_ff == OCC_FULL);
   assign front_prev = (front_ff == '0) ? IDX_LAST : front_ff - IDX_W'(1);
   assign front_next = (front_ff == IDX_LAST) ? '0 : front_ff + IDX_W'(1);
   assign rear_prev  = (rear_ff == '0) ? IDX_LAST : rear_ff - IDX_W'(1);
   assign rear_next  = (rear_ff == IDX_LAST) ? '0 : rear_ff + IDX_W'(1);

   always_comb begin
      front_in   = front_ff;
      rear_in    = rear_ff;
      occ_in     = occ_ff;
      do_wr      = 1'b0;
      do_rd      = 1'b0;
      wr_addr    = '0;
      rd_addr    = front_ff;
      res.status = ST_OK;
      case (req_type)
         OP_INS_FRONT, OP_INS_REAR: begin
            if (was_full) begin
               res.status = ST_OVERFLOW;
            end else begin
               do_wr  = 1'b1;
               occ_in = occ_ff + OCC_W'(1);
               if (was_empty) begin
                  // first word always lands in slot zero
                  front_in = '0;
                  rear_in  = '0;
                  wr_addr  = '0;
               end else if (req_type == OP_INS_FRONT) begin
                  front_in = front_prev;
                  wr_addr  = front_prev;
               end else begin
                  rear_in = rear_next;
                  wr_addr = rear_next;
               end
            end
         end
         OP_REM_FRONT, OP_REM_REAR: begin
            if (was_empty) begin
               res.status = ST_UNDERFLOW;
            end else begin
               do_rd  = 1'b1;
               occ_in = occ_ff - OCC_W'(1);
               if (req_type == OP_REM_FRONT) begin
                  rd_addr  = front_ff;
                  front_in = front_next;
               end else begin
                  rd_addr = rear_ff;
                  rear_in = rear_prev;
               end
               // last word gone: park both indices at slot zero
               if (occ_ff == OCC_W'(1)) begin
                  front_in = '0;
                  rear_in  = '0;
               end
            end
         end
         default: begin
            res.status = ST_OK;
         end
      endcase
      res.is_empty   = (occ_in == '0);
      res.is_full    = (occ_in == OCC_FULL);
      res.rd_pending = do_rd;
   end

   assign wr_en = req_fire && do_wr;
   assign rd_en = req_fire && do_rd;

   always_ff @(posedge clock) begin
      if (reset) begin
         front_ff <= '0;
         rear_ff  <= '0;
         occ_ff   <= '0;
      end else if (req_fire) begin
         front_ff <= front_in;
         rear_ff  <= rear_in;
         occ_ff   <= occ_in;
      end
   end

endmodule

`default_nettype wire

// ----- sim/circular_double_ended_queue_top_tb.sv -----
// Self-checking testbench for the circular double-ended queue top level.
`timescale 1ns / 1ps

module circular_double_ended_queue_top_tb;
   import cdeq_pkg::*;

   localparam int RING_SLOTS = DEPTH_DEF;
   localparam int DIR_ROWS   = 15;
   localparam int HOLD_AT    = 400;   // result count at which the receiver holds off
   localparam int HOLD_LEN   = 300;   // cycles of that hold-off
   localparam int MIX_FILL   = 0;
   localparam int MIX_DRAIN  = 1;
   localparam int MIX_EVEN   = 2;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [DATA_W-1:0]   data_out;
      logic                is_empty;
      logic                is_full;
   } deque_result_type;

   typedef struct packed {
      logic [REQ_TYPE_W-1:0] op;
      logic [DATA_W-1:0]     word;
      logic                  fixed;   // expected result given in the row
      deque_result_type      result;
   } dir_row_type;

   logic                   clock;
   logic                   reset;
   logic                   req_tvalid;
   logic                   req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata;
   logic [REQ_TYPE_W-1:0]  req_tuser;
   logic                   rsp_tvalid;
   logic                   rsp_tready;
   logic [RSP_TDATA_W-1:0] rsp_tdata;
   logic [STATUS_W-1:0]    rsp_tuser;

   // shadow of the deque
   logic [DATA_W-1:0] shadow_ring [RING_SLOTS];
   int                front_pos;
   int                rear_pos;
   int                held_words;

   deque_result_type  pending_results [$];
   int                results_seen;
   int                fault_count;
   int                items_sent;
   dir_row_type       dir_rows [DIR_ROWS];

   circular_double_ended_queue_top dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   initial begin
      #5ms;
      $display("circular_double_ended_queue_top: mismatch");
      $finish;
   end

   function automatic deque_result_type predict_deque_step(input logic [REQ_TYPE_W-1:0] op,
                                                          input logic [DATA_W-1:0] word);
      deque_result_type r;
      r.status   = ST_OK;
      r.data_out = '0;
      if (op == OP_INS_FRONT || op == OP_INS_REAR) begin
         if (held_words >= RING_SLOTS) begin
            r.status = ST_OVERFLOW;
         end else begin
            if (held_words == 0) begin
               front_pos      = 0;
               rear_pos       = 0;
               shadow_ring[0] = word;
            end else if (op == OP_INS_FRONT) begin
               front_pos = (front_pos == 0) ? RING_SLOTS - 1 : front_pos - 1;
               shadow_ring[front_pos] = word;
            end else begin
               rear_pos = (rear_pos == RING_SLOTS - 1) ? 0 : rear_pos + 1;
               shadow_ring[rear_pos] = word;
            end
            held_words++;
         end
      end else begin
         if (held_words == 0) begin
            r.status = ST_UNDERFLOW;
         end else begin
            if (op == OP_REM_FRONT) begin
               r.data_out = shadow_ring[front_pos];
               front_pos  = (front_pos == RING_SLOTS - 1) ? 0 : front_pos + 1;
            end else begin
               r.data_out = shadow_ring[rear_pos];
               rear_pos   = (rear_pos == 0) ? RING_SLOTS - 1 : rear_pos - 1;
            end
            held_words--;
            if (held_words == 0) begin
               front_pos = 0;
               rear_pos  = 0;
            end
         end
      end
      r.is_empty = (held_words == 0);
      r.is_full  = (held_words >= RING_SLOTS);
      return r;
   endfunction

   // Offer one request after an idle gap, which may be empty; record its expected result on transfer.
   task automatic send_request(input logic [REQ_TYPE_W-1:0] op, input logic [DATA_W-1:0] word,
                               input logic fixed, input deque_result_type fixed_result);
      int               gap;
      deque_result_type predicted;
      gap = (((items_sent / 40) % 3) == 0) ? 0 : $urandom_range(0, 15);
      repeat (gap) begin
         @(negedge clock);
         req_tvalid <= 1'b0;
      end
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tdata  <= word;
      req_tuser  <= op;
      do @(posedge clock); while (!req_tready);
      predicted = predict_deque_step(op, word);
      pending_results.push_back(fixed ? fixed_result : predicted);
      items_sent++;
   endtask

   task automatic wait_drained;
      while (pending_results.size() != 0) @(posedge clock);
   endtask

   function automatic logic [DATA_W-1:0] pick_word;
      case ($urandom_range(0, 11))
         0:       return 32'h7FFF_FFFF;
         1:       return 32'h8000_0000;
         2:       return 32'h0000_0000;
         3:       return 32'hFFFF_FFFF;
         default: return $urandom();
      endcase
   endfunction

   function automatic logic [REQ_TYPE_W-1:0] pick_op(input int mix);
      int  insert_tenths;
      logic ins;
      insert_tenths = (mix == MIX_FILL) ? 9 : (mix == MIX_DRAIN) ? 1 : 5;
      ins = ($urandom_range(0, 9) < insert_tenths);
      if (ins) return $urandom_range(0, 1) ? OP_INS_REAR : OP_INS_FRONT;
      else     return $urandom_range(0, 1) ? OP_REM_REAR : OP_REM_FRONT;
   endfunction

   // result side: random stalls, one long hold-off, field checks
   initial begin
      int               gap;
      deque_result_type want;
      deque_result_type got;
      rsp_tready = 1'b0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         if (results_seen == HOLD_AT) gap = HOLD_LEN;
         else if (((results_seen / 50) % 3) == 1) gap = 0;
         else gap = $urandom_range(0, 15);
         repeat (gap) begin
            @(negedge clock);
            rsp_tready <= 1'b0;
         end
         @(negedge clock);
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
         results_seen++;
         got.status   = rsp_tuser;
         got.data_out = rsp_tdata[31:0];
         got.is_empty = rsp_tdata[32];
         got.is_full  = rsp_tdata[33];
         if (pending_results.size() == 0) begin
            $error("result transfer with nothing expected: status %0d data_out %h",
                   got.status, got.data_out);
            fault_count++;
         end else begin
            want = pending_results.pop_front();
            if (got.status !== want.status) begin
               $error("status: expected %0d, got %0d", want.status, got.status);
               fault_count++;
            end
            if (got.data_out !== want.data_out) begin
               $error("data_out: expected %h, got %h", want.data_out, got.data_out);
               fault_count++;
            end
            if (got.is_empty !== want.is_empty) begin
               $error("is_empty: expected %0b, got %0b", want.is_empty, got.is_empty);
               fault_count++;
            end
            if (got.is_full !== want.is_full) begin
               $error("is_full: expected %0b, got %0b", want.is_full, got.is_full);
               fault_count++;
            end
         end
      end
   end

   initial begin
      int mix_plan [5];
      int len_plan [5];
      reset        = 1'b1;
      req_tvalid   = 1'b0;
      req_tdata    = '0;
      req_tuser    = OP_INS_FRONT;
      front_pos    = 0;
      rear_pos     = 0;
      held_words   = 0;
      results_seen = 0;
      fault_count  = 0;
      items_sent   = 0;

      // refused removes, single-word round trips at the extremes, front wrap, drain to empty
      dir_rows[0]  = '{OP_REM_FRONT, 32'h5A5A_5A5A, 1'b1, '{ST_UNDERFLOW, 32'h0, 1'b1, 1'b0}};
      dir_rows[1]  = '{OP_REM_REAR,  32'hA5A5_A5A5, 1'b1, '{ST_UNDERFLOW, 32'h0, 1'b1, 1'b0}};
      dir_rows[2]  = '{OP_INS_FRONT, 32'h7FFF_FFFF, 1'b1, '{ST_OK, 32'h0, 1'b0, 1'b0}};
      dir_rows[3]  = '{OP_REM_REAR,  32'h0,         1'b1, '{ST_OK, 32'h7FFF_FFFF, 1'b1, 1'b0}};
      dir_rows[4]  = '{OP_INS_REAR,  32'h8000_0000, 1'b1, '{ST_OK, 32'h0, 1'b0, 1'b0}};
      dir_rows[5]  = '{OP_REM_FRONT, 32'hFFFF_FFFF, 1'b1, '{ST_OK, 32'h8000_0000, 1'b1, 1'b0}};
      dir_rows[6]  = '{OP_INS_REAR,  32'hFFFF_FFFF, 1'b1, '{ST_OK, 32'h0, 1'b0, 1'b0}};
      dir_rows[7]  = '{OP_INS_FRONT, 32'h0000_0000, 1'b1, '{ST_OK, 32'h0, 1'b0, 1'b0}};
      dir_rows[8]  = '{OP_INS_FRONT, 32'h0000_0001, 1'b0, '0};
      dir_rows[9]  = '{OP_INS_REAR,  32'h1234_5678, 1'b0, '0};
      dir_rows[10] = '{OP_REM_FRONT, 32'h0,         1'b0, '0};
      dir_rows[11] = '{OP_REM_REAR,  32'h0,         1'b0, '0};
      dir_rows[12] = '{OP_REM_REAR,  32'h0,         1'b0, '0};
      dir_rows[13] = '{OP_REM_FRONT, 32'h0,         1'b0, '0};
      dir_rows[14] = '{OP_REM_FRONT, 32'h0,         1'b1, '{ST_UNDERFLOW, 32'h0, 1'b1, 1'b0}};

      mix_plan = '{MIX_FILL, MIX_DRAIN, MIX_EVEN, MIX_FILL, MIX_DRAIN};
      len_plan = '{200, 200, 100, 200, 150};

      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (dir_rows[i])
         send_request(dir_rows[i].op, dir_rows[i].word, dir_rows[i].fixed, dir_rows[i].result);

      // pause until every result is back, then fill, drain and churn at random
      @(negedge clock);
      req_tvalid <= 1'b0;
      wait_drained();

      foreach (mix_plan[s])
         for (int n = 0; n < len_plan[s]; n++)
            send_request(pick_op(mix_plan[s]), pick_word(), 1'b0, '0);

      @(negedge clock);
      req_tvalid <= 1'b0;
      wait_drained();
      repeat (20) @(posedge clock);

      if (fault_count == 0)
         $display("circular_double_ended_queue_top: match");
      else
         $display("circular_double_ended_queue_top: mismatch");
      $finish;
   end

endmodule

// ----- circular_double_ended_queue_top.f -----
hdl/cdeq_pkg.sv
hdl/cdeq_ring.sv
hdl/cdeq_ctrl.sv
hdl/circular_double_ended_queue_top.sv
sim/circular_double_ended_queue_top_tb.sv
